### design/ssre_pkg.sv
// ----------------------------------------------------------------------------
// ssre_pkg - shared definitions for the stack sort/reverse engine
// Stack depth, field widths, command and status codes, sequencer states and
// the result word passed from the core to the output stage.
// ----------------------------------------------------------------------------
package ssre_pkg;

  localparam int DEPTH = 16;
  localparam int DW    = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_BOTTOM  = 3'd3,
    CMD_REVERSE = 3'd4,
    CMD_SORTED  = 3'd5,
    CMD_SORT    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_SORT_RD,
    S_SORT_LD,
    S_REV_RLO,
    S_REV_RHI,
    S_REV_WLO,
    S_REV_WHI,
    S_FETCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [DW-1:0] data;
    logic [CW-1:0]        count;
    logic                 is_empty;
    status_t              status;
  } res_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic signed [DW-1:0] value;
  } req_t;

endpackage

### design/ssre_core.sv
// ----------------------------------------------------------------------------
// ssre_core - stack store and command sequencer
// Single-port-read, single-port-write store walked by a small sequencer with
// one shared signed comparator for sorted insert and sort.
// ----------------------------------------------------------------------------
module ssre_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ssre_pkg::req_t    req,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_take,
  output ssre_pkg::res_t    res
);

  logic signed [ssre_pkg::DW-1:0] mem [ssre_pkg::DEPTH];

  ssre_pkg::state_t  state_r, state_nxt;
  ssre_pkg::cmd_t    mode_r, mode_nxt;
  ssre_pkg::status_t status_r, status_nxt;
  logic [ssre_pkg::CW-1:0] count_r, count_nxt;
  logic [ssre_pkg::CW-1:0] pos_r, pos_nxt;
  logic [ssre_pkg::CW-1:0] lo_r, lo_nxt;
  logic [ssre_pkg::CW-1:0] hi_r, hi_nxt;
  logic [ssre_pkg::CW-1:0] n_r, n_nxt;
  logic                    popped_r, popped_nxt;
  logic signed [ssre_pkg::DW-1:0] v_r, v_nxt;
  logic signed [ssre_pkg::DW-1:0] tmp_r, tmp_nxt;
  logic signed [ssre_pkg::DW-1:0] rdata_r;

  logic [ssre_pkg::CW-1:0] pos_m1, cnt_m1, cnt_p1, hi_m1, lo_p1;
  logic [ssre_pkg::AW-1:0] raddr, waddr;
  logic signed [ssre_pkg::DW-1:0] wdata;
  logic we;
  logic ge;

  assign pos_m1 = pos_r - ssre_pkg::CW'(1);
  assign cnt_m1 = count_r - ssre_pkg::CW'(1);
  assign cnt_p1 = count_r + ssre_pkg::CW'(1);
  assign hi_m1  = hi_r - ssre_pkg::CW'(1);
  assign lo_p1  = lo_r + ssre_pkg::CW'(1);

  // shared comparator: stored word at or above the word being placed
  assign ge = (rdata_r >= v_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ssre_pkg::S_IDLE;
      count_r  <= '0;
      status_r <= ssre_pkg::ST_OK;
      popped_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      popped_r <= popped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    pos_r  <= pos_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    n_r    <= n_nxt;
    v_r    <= v_nxt;
    tmp_r  <= tmp_nxt;
  end

  always_comb begin
    logic finish;
    finish     = 1'b0;
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    n_nxt      = n_r;
    v_nxt      = v_r;
    tmp_nxt    = tmp_r;
    popped_nxt = popped_r;
    we         = 1'b0;
    waddr      = pos_r[ssre_pkg::AW-1:0];
    wdata      = v_r;
    // default read: top word (or the popped word) for the result
    raddr      = popped_r ? count_r[ssre_pkg::AW-1:0] : cnt_m1[ssre_pkg::AW-1:0];

    unique case (state_r)
      ssre_pkg::S_IDLE: begin
        if (start) begin
          mode_nxt   = req.cmd;
          v_nxt      = req.value;
          pos_nxt    = count_r;
          lo_nxt     = '0;
          hi_nxt     = count_r;
          status_nxt = ssre_pkg::ST_OK;
          popped_nxt = 1'b0;
          state_nxt  = ssre_pkg::S_FETCH;
          unique case (req.cmd) inside
            ssre_pkg::CMD_PUSH, ssre_pkg::CMD_BOTTOM, ssre_pkg::CMD_SORTED: begin
              if (count_r >= ssre_pkg::CW'(ssre_pkg::DEPTH)) begin
                status_nxt = ssre_pkg::ST_OVER;
              end else begin
                state_nxt = ssre_pkg::S_WALK_RD;
              end
            end
            ssre_pkg::CMD_POP: begin
              if (count_r == '0) begin
                status_nxt = ssre_pkg::ST_UNDER;
              end else begin
                count_nxt  = cnt_m1;
                popped_nxt = 1'b1;
              end
            end
            ssre_pkg::CMD_PEEK: begin
              if (count_r == '0) begin
                status_nxt = ssre_pkg::ST_UNDER;
              end
            end
            ssre_pkg::CMD_REVERSE: begin
              state_nxt = ssre_pkg::S_REV_RLO;
            end
            ssre_pkg::CMD_SORT: begin
              // rebuild in place: entries below the build count are sorted
              n_nxt     = count_r;
              count_nxt = '0;
              if (count_r != '0) begin
                state_nxt = ssre_pkg::S_SORT_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ssre_pkg::S_WALK_RD: begin
        if (pos_r == '0 || mode_r == ssre_pkg::CMD_PUSH) begin
          we     = 1'b1;
          wdata  = v_r;
          finish = 1'b1;
        end else begin
          raddr     = pos_m1[ssre_pkg::AW-1:0];
          state_nxt = ssre_pkg::S_WALK_CMP;
        end
      end

      ssre_pkg::S_WALK_CMP: begin
        we = 1'b1;
        if (mode_r == ssre_pkg::CMD_BOTTOM || ge) begin
          // move the word up one slot and keep walking down
          wdata     = rdata_r;
          pos_nxt   = pos_m1;
          state_nxt = ssre_pkg::S_WALK_RD;
        end else begin
          wdata  = v_r;
          finish = 1'b1;
        end
      end

      ssre_pkg::S_SORT_RD: begin
        raddr     = count_r[ssre_pkg::AW-1:0];
        state_nxt = ssre_pkg::S_SORT_LD;
      end

      ssre_pkg::S_SORT_LD: begin
        v_nxt     = rdata_r;
        pos_nxt   = count_r;
        state_nxt = ssre_pkg::S_WALK_RD;
      end

      ssre_pkg::S_REV_RLO: begin
        if (hi_r > lo_p1) begin
          raddr     = lo_r[ssre_pkg::AW-1:0];
          state_nxt = ssre_pkg::S_REV_RHI;
        end else begin
          state_nxt = ssre_pkg::S_FETCH;
        end
      end

      ssre_pkg::S_REV_RHI: begin
        tmp_nxt   = rdata_r;
        raddr     = hi_m1[ssre_pkg::AW-1:0];
        state_nxt = ssre_pkg::S_REV_WLO;
      end

      ssre_pkg::S_REV_WLO: begin
        we        = 1'b1;
        waddr     = lo_r[ssre_pkg::AW-1:0];
        wdata     = rdata_r;
        state_nxt = ssre_pkg::S_REV_WHI;
      end

      ssre_pkg::S_REV_WHI: begin
        we        = 1'b1;
        waddr     = hi_m1[ssre_pkg::AW-1:0];
        wdata     = tmp_r;
        lo_nxt    = lo_p1;
        hi_nxt    = hi_m1;
        state_nxt = ssre_pkg::S_REV_RLO;
      end

      ssre_pkg::S_FETCH: begin
        state_nxt = ssre_pkg::S_DONE;
      end

      ssre_pkg::S_DONE: begin
        if (res_take) begin
          state_nxt = ssre_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ssre_pkg::S_IDLE;
      end
    endcase

    if (finish) begin
      count_nxt = cnt_p1;
      if (mode_r == ssre_pkg::CMD_SORT && cnt_p1 < n_r) begin
        state_nxt = ssre_pkg::S_SORT_RD;
      end else begin
        state_nxt = ssre_pkg::S_FETCH;
      end
    end
  end

  assign idle      = (state_r == ssre_pkg::S_IDLE);
  assign res_valid = (state_r == ssre_pkg::S_DONE);

  always_comb begin
    res.data     = (popped_r || count_r != '0) ? rdata_r : '0;
    res.count    = count_r;
    res.is_empty = (count_r == '0);
    res.status   = status_r;
  end

endmodule

### design/stack_sort_reverse_engine_top.sv
// ----------------------------------------------------------------------------
// stack_sort_reverse_engine_top - bounded stack with reverse and sort
// Input word in, one result word out per command; registered output stage.
// ----------------------------------------------------------------------------
// Path to the output register: pop, peek, no-op and a refused insert go straight
// to the fetch state; push writes the top slot; insert bottom moves every entry
// up one slot, sorted insert only until a compare ends the walk; reverse swaps
// pairs from both ends inward; sort reinserts each entry. The next word is taken
// the cycle after the result leaves the core, so one word is in flight at a time.
// Reset (synchronous, rst_n low) empties the stack; stored words stay undefined.
module stack_sort_reverse_engine_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_cmd,
  input  logic signed [ssre_pkg::DW-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [ssre_pkg::DW-1:0] out_data,
  output logic [ssre_pkg::CW-1:0]        out_count,
  output logic                           out_is_empty,
  output logic [1:0]                     out_status
);

  ssre_pkg::req_t req;
  ssre_pkg::res_t res;
  ssre_pkg::res_t out_r;
  logic out_valid_r;
  logic core_idle, res_valid, res_take, start;

  assign in_stall = !core_idle;
  assign start    = in_valid && core_idle;
  assign req.cmd   = ssre_pkg::cmd_t'(in_cmd);
  assign req.value = in_value;

  // take a finished result whenever the output register is free or draining
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  ssre_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r.data;
  assign out_count    = out_r.count;
  assign out_is_empty = out_r.is_empty;
  assign out_status   = out_r.status;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= ssre_pkg::CW'(ssre_pkg::DEPTH)))
    else $error("count beyond stack depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ssre_pkg::ST_OVER)
      |-> (out_count == ssre_pkg::CW'(ssre_pkg::DEPTH)))
    else $error("overflow reported on a stack that is not full");

  a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ssre_pkg::ST_UNDER)
      |-> (out_is_empty && out_data == '0))
    else $error("underflow reported with entries or data");

endmodule
